[hdl/ehc_pkg.sv]
// edge coverage hit counter: shared types and constants
// word structs, controller state enum, command and status groups
// no dependencies
package ehc_pkg;

  // field widths of the words
  localparam int unsigned AddrW    = 64;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgW     = 5;
  localparam int unsigned HashW    = 32;
  localparam int unsigned PrevLocW = 31;

  // xorshift amounts of the block hash
  localparam int unsigned ShiftA = 12;
  localparam int unsigned ShiftB = 25;
  localparam int unsigned ShiftC = 27;

  // saturation value of a counter
  localparam logic [CountW-1:0] HitMax = 8'd255;

  // reset value of the index-bits register
  localparam logic [CfgW-1:0] CfgBitsReset = 5'd16;

  // word modes
  localparam logic ModeRecord = 1'b0;
  localparam logic ModeRead   = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [AddrW-1:0]  block_address;
    logic [IndexW-1:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [IndexW-1:0] edge_index;
    logic [CountW-1:0] hit_count;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;    // write zero at the sweep address and advance it
    logic in_ready; // block takes an input word
    logic capture;  // input word accepted this cycle
    logic update;   // write back the counter (record mode) and load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done; // sweep address at the last counter
    logic out_free; // output register empty or being taken
  } dp_status_t;

endpackage

[hdl/edge_coverage_hit_counter.sv]
// edge coverage hit counter: top level
// one word at a time: the counter memory read-modify-write (read, then write-back)
// ends before the next word is taken; the result loads the output register at write-back
// after reset a sweep clears all 2^MAP_INDEX_BITS counters, one per cycle,
// and no word is taken during the sweep
// depends on ehc_pkg, ehc_ctrl, ehc_datapath
module edge_coverage_hit_counter #(
  parameter int unsigned MAP_INDEX_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  ehc_pkg::in_word_t        in_word_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output ehc_pkg::out_word_t       out_word_o,
  input  logic                     cfg_we_i,
  input  logic [ehc_pkg::CfgW-1:0] cfg_wdata_i
);
  import ehc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // controller
  ehc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath
  ehc_datapath #(
    .MAP_INDEX_BITS (MAP_INDEX_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  assign in_stall_o = !cmd.in_ready;

  // no word taken during the clearing sweep
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> in_stall_o)
    else $error("word accepted during clearing sweep");

  // one word at a time: busy in the cycle after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous word in flight");

  // write-back never overwrites a result still waiting
  a_update_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");

endmodule

[hdl/ehc_ctrl.sv]
// edge coverage hit counter: controller state machine
// sequences clearing sweep, counter read and write-back
// depends on ehc_pkg
module ehc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  ehc_pkg::dp_status_t status_i,
  output ehc_pkg::ctrl_cmd_t  cmd_o
);
  import ehc_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.update = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hdl/ehc_datapath.sv]
// edge coverage hit counter: datapath
// hash, index mask, counter memory, previous location and output register
// depends on ehc_pkg
module ehc_datapath #(
  parameter int unsigned MAP_INDEX_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ehc_pkg::ctrl_cmd_t           cmd_i,
  output ehc_pkg::dp_status_t          status_o,
  input  ehc_pkg::in_word_t            in_word_i,
  input  logic                         cfg_we_i,
  input  logic [ehc_pkg::CfgW-1:0]     cfg_wdata_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output ehc_pkg::out_word_t           out_word_o
);
  import ehc_pkg::*;

  localparam int unsigned Depth = 1 << MAP_INDEX_BITS;
  localparam logic [5:0] MapBits = 6'(MAP_INDEX_BITS);

  // index-bits register
  logic [CfgW-1:0] cfg_bits_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_bits_q <= CfgBitsReset;
    end else if (cfg_we_i) begin
      cfg_bits_q <= cfg_wdata_i;
    end
  end

  // clamp to the range one .. map bits, then build the index mask
  logic [5:0]                eff_bits;
  logic [MAP_INDEX_BITS-1:0] idx_mask;
  always_comb begin
    eff_bits = {1'b0, cfg_bits_q};
    if (eff_bits == 6'd0) begin
      eff_bits = 6'd1;
    end else if (eff_bits > MapBits) begin
      eff_bits = MapBits;
    end
  end

  for (genvar i = 0; i < MAP_INDEX_BITS; i++) begin : g_mask
    assign idx_mask[i] = (6'(i) < eff_bits);
  end

  // three xorshifts on the block address, low word kept
  logic [AddrW-1:0] h1, h2, h3;
  logic [HashW-1:0] hash;
  assign h1   = in_word_i.block_address ^ (in_word_i.block_address >> ShiftA);
  assign h2   = h1 ^ (h1 << ShiftB);
  assign h3   = h2 ^ (h2 >> ShiftC);
  assign hash = h3[HashW-1:0];

  // previous location
  logic [PrevLocW-1:0] loc_hist_q;
  logic [HashW-1:0]    mix;
  assign mix = {1'b0, loc_hist_q} ^ hash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_hist_q <= '0;
    end else if (cmd_i.capture && (in_word_i.mode == ModeRecord)) begin
      loc_hist_q <= hash[HashW-1:1];
    end
  end

  // counter index and echoed index of the incoming word
  logic [MAP_INDEX_BITS-1:0] rec_idx, rd_idx;
  logic [31:0]               rec_idx_ext, rd_idx_ext;
  assign rec_idx     = mix[MAP_INDEX_BITS-1:0] & idx_mask;
  assign rec_idx_ext = 32'(rec_idx);
  assign rd_idx_ext  = 32'(in_word_i.read_index);
  assign rd_idx      = rd_idx_ext[MAP_INDEX_BITS-1:0];

  // captured word
  logic                      mode_q;
  logic [MAP_INDEX_BITS-1:0] mem_idx_q;
  logic [IndexW-1:0]         echo_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= in_word_i.mode;
      if (in_word_i.mode == ModeRecord) begin
        mem_idx_q <= rec_idx;
        echo_q    <= rec_idx_ext[IndexW-1:0];
      end else begin
        mem_idx_q <= rd_idx;
        echo_q    <= in_word_i.read_index;
      end
    end
  end

  // clearing sweep address
  logic [MAP_INDEX_BITS-1:0] clr_addr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end
  assign status_o.clr_done = (clr_addr_q == '1);

  // saturating increment of the stored count
  logic [CountW-1:0] rdata_q;
  logic [CountW-1:0] sat_count;
  assign sat_count = (rdata_q == HitMax) ? HitMax : rdata_q + 1'b1;

  // counter memory: one write port, one registered read port
  logic [CountW-1:0]         mem [Depth];
  logic                      mem_we;
  logic [MAP_INDEX_BITS-1:0] mem_waddr;
  logic [CountW-1:0]         mem_wdata;
  assign mem_we    = cmd_i.clear || (cmd_i.update && (mode_q == ModeRecord));
  assign mem_waddr = cmd_i.clear ? clr_addr_q : mem_idx_q;
  assign mem_wdata = cmd_i.clear ? '0 : sat_count;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_idx_q];
  end

  // output register
  logic      out_valid_q;
  out_word_t out_word_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.update) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      out_word_q.edge_index <= echo_q;
      out_word_q.hit_count  <= (mode_q == ModeRecord) ? sat_count : rdata_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
